// ===== rtl/core/cfrc_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the chunked file receive checker.
// Used by cfrc_res_fifo and chunked_file_receive_checker; depends on nothing else.
`timescale 1ns / 1ps

package cfrc_pkg;

  // Protocol limits and CRC constants.
  localparam int unsigned NAME_LIMIT = 30;
  localparam logic [5:0]  POS_MAX    = 6'd63;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED   = 32'hFFFF_FFFF;

  // Payload tags.
  localparam logic [7:0] TAG_START = 8'd1;
  localparam logic [7:0] TAG_CHUNK = 8'd2;
  localparam logic [7:0] TAG_END   = 8'd3;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_START    = 2'd0,
    PHASE_DONE     = 2'd1,
    PHASE_PROGRESS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_OPEN  = 2'd1,
    ST_CRC_BAD  = 2'd2,
    ST_SIZE_BAD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_UNDECIDED = 2'd0,
    CM_PASS      = 2'd1,
    CM_IGNORE    = 2'd2
  } chunk_mode_t;

  // One result word as it leaves the block.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    phase_t      phase;
    status_t     status;
    logic [47:0] dest;
    logic        last;
  } result_t;

  // Up to two results pushed into the queue for one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Reflected CRC-32 update over one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cfrc_res_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one while out_ready is high.
// Depends on cfrc_pkg for the result and push types.
`timescale 1ns / 1ps

module cfrc_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  cfrc_pkg::push_t   push,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output cfrc_pkg::result_t out_res
);

  logic [cfrc_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cfrc_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cfrc_pkg::FIFO_AW:0]   count_r, count_nxt;
  logic [cfrc_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic                         pop;
  cfrc_pkg::result_t            mem_r [cfrc_pkg::FIFO_DEPTH];

  // Status toward both sides.
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= (cfrc_pkg::FIFO_AW + 1)'(cfrc_pkg::FIFO_DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + cfrc_pkg::FIFO_AW'(1);

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cfrc_pkg::FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + cfrc_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + (cfrc_pkg::FIFO_AW + 1)'(push.cnt)
               - (cfrc_pkg::FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage: first result at the write pointer, second one after it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < cfrc_pkg::FIFO_DEPTH; i++) begin
      if (push.cnt != 2'd0 && wr_ptr_r == cfrc_pkg::FIFO_AW'(i)) begin
        mem_r[i] <= push.r0;
      end
      if (push.cnt == 2'd2 && wr_ptr_p1 == cfrc_pkg::FIFO_AW'(i)) begin
        mem_r[i] <= push.r1;
      end
    end
  end

endmodule

// ===== rtl/core/chunked_file_receive_checker.sv =====
// Top level of the chunked file receive checker: input register, protocol state and checks.
// Depends on cfrc_pkg and on cfrc_res_fifo for the result queue.
`timescale 1ns / 1ps

// The block takes one payload byte per cycle on the in_ stream and answers on the out_ stream
// with data bytes to store, acknowledgements (start, done, progress) and gap aborts. A byte
// sits in the input register, where the whole protocol step, including the unrolled CRC-32
// byte update, is done combinationally; its results are written into the storage registers
// of a four-entry queue and read from there onto out_. The output side moves one result per
// cycle while out_tready is high, and a chunk's final byte that also triggers a progress ack
// puts two results into the queue; the input keeps taking one byte per cycle as long as the
// queue has room for two more results. The user must write the progress interval through
// cfg_valid/cfg_data only while idle; the block does not enforce this. cfg_ready is always high.

module chunked_file_receive_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [7:0] payload_byte, [55:8] source_addr, [56] store_ready
  input  logic        in_tlast,   // last_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] data_byte, [9:8] ack_phase, [11:10] ack_status,
                                  // [59:12] dest_addr
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast,  // last_result
  // Configuration: ack_every_log2
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  // Input register.
  logic        s1_v_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [47:0] s1_src_r;
  logic        s1_rdy_r;

  // Protocol state.
  logic [3:0]             ack_every_log2_r;
  logic                   recv_r, recv_nxt;
  logic [7:0]             tag_r, tag_nxt;
  logic [5:0]             pos_r, pos_nxt;
  logic [4:0]             nl_r, nl_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [31:0]            exp_r, exp_nxt;
  logic [31:0]            count_r, count_nxt;
  logic [15:0]            ns_r, ns_nxt;
  logic [7:0]             seql_r, seql_nxt;
  cfrc_pkg::chunk_mode_t  cm_r, cm_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            ec_r, ec_nxt;

  // Step signals.
  logic                   room2;
  logic                   advance;
  logic                   in_acc;
  logic                   pre_v, ack_v;
  cfrc_pkg::result_t      pre_res, ack_res;
  cfrc_pkg::push_t        push;
  cfrc_pkg::result_t      out_res;

  // Replace one byte of a little-endian word.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[idx*8 +: 8] = b;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign advance   = s1_v_r && room2;
  assign in_tready = !s1_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata[7:0];
      s1_src_r  <= in_tdata[55:8];
      s1_rdy_r  <= in_tdata[56];
      s1_last_r <= in_tlast;
    end
  end

  // One protocol step for the registered byte.
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  tag;
    logic [6:0]  nl_sum;
    logic [6:0]  off;
    logic [15:0] d;
    logic [15:0] mask;

    b      = s1_byte_r;
    tag    = (pos_r == 6'd0) ? b : tag_r;
    nl_sum = {2'b00, nl_r} + 7'd2;
    off    = {1'b0, pos_r} - nl_sum;
    d      = {b, seql_r} - ns_r;
    mask   = ~(16'hFFFF << ack_every_log2_r);

    recv_nxt  = recv_r;
    tag_nxt   = tag;
    nl_nxt    = nl_r;
    size_nxt  = size_r;
    exp_nxt   = exp_r;
    count_nxt = count_r;
    ns_nxt    = ns_r;
    seql_nxt  = seql_r;
    cm_nxt    = (pos_r == 6'd0) ? cfrc_pkg::CM_UNDECIDED : cm_r;
    crc_nxt   = crc_r;
    ec_nxt    = ec_r;

    pre_v          = 1'b0;
    pre_res.kind   = cfrc_pkg::KIND_DATA;
    pre_res.data   = 8'd0;
    pre_res.phase  = cfrc_pkg::PHASE_START;
    pre_res.status = cfrc_pkg::ST_OK;
    pre_res.dest   = 48'd0;
    pre_res.last   = 1'b1;

    ack_v          = 1'b0;
    ack_res.kind   = cfrc_pkg::KIND_ACK;
    ack_res.data   = 8'd0;
    ack_res.phase  = cfrc_pkg::PHASE_START;
    ack_res.status = cfrc_pkg::ST_OK;
    ack_res.dest   = s1_src_r;
    ack_res.last   = 1'b1;

    // Byte handling by payload tag.
    if (tag == cfrc_pkg::TAG_START) begin
      if (pos_r == 6'd1) begin
        nl_nxt = (b < 8'(cfrc_pkg::NAME_LIMIT)) ? b[4:0] : 5'(cfrc_pkg::NAME_LIMIT);
      end else if ({1'b0, pos_r} >= nl_sum && off < 7'd4) begin
        size_nxt = put_byte(size_r, off[1:0], b);
      end
    end else if (tag == cfrc_pkg::TAG_CHUNK) begin
      if (pos_r == 6'd1) begin
        seql_nxt = b;
      end else if (pos_r == 6'd2) begin
        if (recv_r) begin
          if (d == 16'd0) begin
            cm_nxt = cfrc_pkg::CM_PASS;
          end else begin
            cm_nxt = cfrc_pkg::CM_IGNORE;
            if (!d[15]) begin
              // Sequence ran ahead: drop the transfer.
              recv_nxt     = 1'b0;
              pre_v        = 1'b1;
              pre_res.kind = cfrc_pkg::KIND_ABORT;
            end
          end
        end else begin
          cm_nxt = cfrc_pkg::CM_IGNORE;
        end
      end else if (pos_r >= 6'd3 && cm_nxt == cfrc_pkg::CM_PASS) begin
        pre_v        = 1'b1;
        pre_res.data = b;
        crc_nxt      = cfrc_pkg::crc_byte(crc_r, b);
        count_nxt    = count_r + 32'd1;
      end
    end else if (tag == cfrc_pkg::TAG_END) begin
      if (pos_r >= 6'd1 && pos_r <= 6'd4) begin
        ec_nxt = put_byte(ec_r, 2'(pos_r - 6'd1), b);
      end
    end

    // End of payload.
    if (s1_last_r) begin
      if (tag == cfrc_pkg::TAG_START) begin
        if (pos_r != 6'd0 && ({1'b0, pos_r} + 7'd1 >= {2'b00, nl_nxt} + 7'd6)) begin
          exp_nxt = size_nxt;
          ack_v   = 1'b1;
          if (s1_rdy_r) begin
            recv_nxt  = 1'b1;
            ns_nxt    = 16'd0;
            count_nxt = 32'd0;
            crc_nxt   = cfrc_pkg::CRC_SEED;
          end else begin
            recv_nxt       = 1'b0;
            ack_res.status = cfrc_pkg::ST_NO_OPEN;
          end
        end
      end else if (tag == cfrc_pkg::TAG_CHUNK) begin
        if (cm_nxt == cfrc_pkg::CM_PASS) begin
          ns_nxt = ns_r + 16'd1;
          if ((ns_nxt & mask) == 16'd0) begin
            ack_v         = 1'b1;
            ack_res.phase = cfrc_pkg::PHASE_PROGRESS;
          end
        end
      end else if (tag == cfrc_pkg::TAG_END) begin
        if (recv_r) begin
          recv_nxt      = 1'b0;
          ack_v         = 1'b1;
          ack_res.phase = cfrc_pkg::PHASE_DONE;
          if (count_r != exp_r) begin
            ack_res.status = cfrc_pkg::ST_SIZE_BAD;
          end else if (pos_r >= 6'd4 && ec_nxt != ~crc_r) begin
            ack_res.status = cfrc_pkg::ST_CRC_BAD;
          end
        end
      end
      pos_nxt = 6'd0;
      cm_nxt  = cfrc_pkg::CM_UNDECIDED;
    end else begin
      pos_nxt = (pos_r == cfrc_pkg::POS_MAX) ? cfrc_pkg::POS_MAX : pos_r + 6'd1;
    end
  end

  // Order the results of this byte for the queue.
  always_comb begin
    push.cnt = 2'd0;
    push.r0  = ack_res;
    push.r1  = ack_res;
    if (pre_v) begin
      push.r0      = pre_res;
      push.r0.last = !ack_v;
    end
    if (advance) begin
      push.cnt = 2'(pre_v) + 2'(ack_v);
    end
  end

  // State update and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_every_log2_r <= 4'd5;
      recv_r  <= 1'b0;
      tag_r   <= 8'd0;
      pos_r   <= 6'd0;
      nl_r    <= 5'd0;
      size_r  <= 32'd0;
      exp_r   <= 32'd0;
      count_r <= 32'd0;
      ns_r    <= 16'd0;
      seql_r  <= 8'd0;
      cm_r    <= cfrc_pkg::CM_UNDECIDED;
      crc_r   <= cfrc_pkg::CRC_SEED;
      ec_r    <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ack_every_log2_r <= cfg_data;
      end
      if (advance) begin
        recv_r  <= recv_nxt;
        tag_r   <= tag_nxt;
        pos_r   <= pos_nxt;
        nl_r    <= nl_nxt;
        size_r  <= size_nxt;
        exp_r   <= exp_nxt;
        count_r <= count_nxt;
        ns_r    <= ns_nxt;
        seql_r  <= seql_nxt;
        cm_r    <= cm_nxt;
        crc_r   <= crc_nxt;
        ec_r    <= ec_nxt;
      end
    end
  end

  // Result queue.
  cfrc_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Output word packing.
  assign out_tdata = {4'd0, out_res.dest, out_res.status, out_res.phase, out_res.data};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
